### rtl/core/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, codes, state type, index helpers and generation helper of the id allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

   localparam int ENTRIES   = 256;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int WORD_BITS = (ENTRIES < 32) ? ENTRIES : 32;
   localparam int WORDS     = ENTRIES / WORD_BITS;
   localparam int ROW_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ID_W      = 32;
   localparam int RSV_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(WORDS - 1);
   localparam logic [ID_W-1:0]  ALL_ONES = '1;

   // request codes
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_ALLOC = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_DONE  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_MASK = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FREE_WR,
      S_INIT,
      S_FINISH
   } state_type;

   function automatic logic [ROW_W-1:0] row_of(logic [IDX_W-1:0] idx);
      logic [IDX_W:0] t;
      t = {1'b0, idx} >> BIT_W;
      return t[ROW_W-1:0];
   endfunction

   function automatic logic [BIT_W-1:0] bit_of(logic [IDX_W-1:0] idx);
      return idx[BIT_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] make_idx(logic [ROW_W-1:0] row,
                                                 logic [BIT_W-1:0] b);
      logic [IDX_W+ROW_W-1:0] t;
      t = ((IDX_W+ROW_W)'(row) << BIT_W) | (IDX_W+ROW_W)'(b);
      return t[IDX_W-1:0];
   endfunction

   function automatic logic [ID_W-1:0] next_gen(logic [ID_W-1:0] gen,
                                                logic [ID_W-1:0] mask);
      return (gen + ID_W'(ENTRIES)) & mask;
   endfunction

endpackage

### rtl/core/bia_if.sv
// ----------------------------------------------------------------------------
// bia_if
// Request, response and register write channels of the id allocator.
// ----------------------------------------------------------------------------
interface bia_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [bia_pkg::ID_W-1:0]  obj_id;

   modport source (output valid, output req_type, output obj_id, input ready);
   modport sink   (input valid, input req_type, input obj_id, output ready);
endinterface

interface bia_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bia_pkg::ID_W-1:0]  result_id;
   logic [1:0]                status;

   modport source (output valid, output result_id, output status, input ready);
   modport sink   (input valid, input result_id, input status, output ready);
endinterface

interface bia_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bia_pkg::CSR_IDX_W-1:0]  index;
   logic [bia_pkg::CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/bia_ram.sv
// ----------------------------------------------------------------------------
// bia_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bia_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bia_ffz.sv
// ----------------------------------------------------------------------------
// bia_ffz
// Find-first-zero unit over one bitmap word, starting at a given bit.
// ----------------------------------------------------------------------------
module bia_ffz (
   input  logic [bia_pkg::WORD_BITS-1:0] word,
   input  logic [bia_pkg::BIT_W-1:0]     start,
   output logic                          found,
   output logic [bia_pkg::BIT_W-1:0]     pos
);

   logic [bia_pkg::WORD_BITS-1:0] low_mask;
   logic [bia_pkg::WORD_BITS-1:0] masked;

   assign low_mask = ~({bia_pkg::WORD_BITS{1'b1}} << start);
   assign masked   = word | low_mask;

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = bia_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (!masked[i]) begin
            found = 1'b1;
            pos   = bia_pkg::BIT_W'(i);
         end
      end
   end

endmodule

### rtl/core/bitmap_id_allocator.sv
// allocate: accept, then scan one bitmap word per cycle through the find-first-zero unit
//   (up to 2*WORDS words over both passes), then output
// free: row read, read-modify-write, output; init: one bitmap row written per cycle
//   over all WORDS rows, then output; unused request code: straight to output
// one request in flight; a finished response waits in its own output register
// reset: map rows marked invalid (read as free), hint, generation and registers zeroed
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Bitmap id pool with generation bits, word-serial first-free search.
// ----------------------------------------------------------------------------
module bitmap_id_allocator (
   input  logic         clock,
   input  logic         reset,
   bia_req_if.sink      req_ch,
   bia_rsp_if.source    rsp_ch,
   bia_csr_if.sink      csr_ch
);

   bia_pkg::state_type                state_ff, state_in;
   logic [bia_pkg::ROW_W-1:0]         row_ff, row_in;
   logic [bia_pkg::BIT_W-1:0]         start_ff, start_in;
   logic                              pass_ff, pass_in;
   logic [bia_pkg::CNT_W-1:0]         rem_ff, rem_in;
   logic [bia_pkg::IDX_W-1:0]         hint_ff, hint_in;
   logic [bia_pkg::ID_W-1:0]          gen_ff, gen_in;
   logic [bia_pkg::ID_W-1:0]          top_mask_ff, top_mask_in;
   logic [bia_pkg::RSV_W-1:0]         reserved_ff, reserved_in;
   logic [bia_pkg::WORDS-1:0]         valid_ff, valid_in;
   logic [bia_pkg::ID_W-1:0]          res_ff, res_in;
   logic [1:0]                        stat_ff, stat_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bia_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;

   logic                              req_fire;
   logic                              rsp_free;
   logic [bia_pkg::IDX_W-1:0]         free_idx;
   logic [bia_pkg::ROW_W-1:0]         next_row;
   logic                              last_row;
   logic [bia_pkg::WORD_BITS-1:0]     word_cur;
   logic                              ffz_found;
   logic [bia_pkg::BIT_W-1:0]         ffz_pos;

   logic                              ram_wr_en;
   logic [bia_pkg::WORD_BITS-1:0]     ram_wr_data;
   logic                              ram_rd_en;
   logic [bia_pkg::ROW_W-1:0]         ram_rd_addr;
   logic [bia_pkg::WORD_BITS-1:0]     ram_rd_data;

   assign req_ch.ready     = (state_ff == bia_pkg::S_IDLE);
   assign req_fire         = req_ch.valid && req_ch.ready;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result_id = rsp_id_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_free         = !rsp_valid_ff || rsp_ch.ready;

   assign free_idx = req_ch.obj_id[bia_pkg::IDX_W-1:0];
   assign last_row = (row_ff == bia_pkg::LAST_ROW);
   assign next_row = last_row ? '0 : row_ff + 1'b1;
   assign word_cur = valid_ff[row_ff] ? ram_rd_data : '0;

   bia_ram #(
      .WIDTH (bia_pkg::WORD_BITS),
      .DEPTH (bia_pkg::WORDS),
      .ADDR_W(bia_pkg::ROW_W)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(row_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   bia_ffz u_ffz (
      .word (word_cur),
      .start(start_ff),
      .found(ffz_found),
      .pos  (ffz_pos)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bia_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type)
                  bia_pkg::REQ_ALLOC: state_in = bia_pkg::S_SCAN;
                  bia_pkg::REQ_FREE:  state_in = bia_pkg::S_FREE_WR;
                  bia_pkg::REQ_INIT:  state_in = bia_pkg::S_INIT;
                  default:            state_in = bia_pkg::S_FINISH;
               endcase
            end
         end
         bia_pkg::S_SCAN: begin
            if (ffz_found || (last_row && pass_ff)) begin
               state_in = bia_pkg::S_FINISH;
            end
         end
         bia_pkg::S_FREE_WR: state_in = bia_pkg::S_FINISH;
         bia_pkg::S_INIT: begin
            if (last_row) begin
               state_in = bia_pkg::S_FINISH;
            end
         end
         bia_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = bia_pkg::S_IDLE;
            end
         end
         default: state_in = bia_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      row_in        = row_ff;
      start_in      = start_ff;
      pass_in       = pass_ff;
      rem_in        = rem_ff;
      hint_in       = hint_ff;
      gen_in        = gen_ff;
      top_mask_in   = top_mask_ff;
      reserved_in   = reserved_ff;
      valid_in      = valid_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = next_row;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            bia_pkg::CSR_TOP_MASK: top_mask_in = csr_ch.data;
            bia_pkg::CSR_RESERVED: reserved_in = csr_ch.data[bia_pkg::RSV_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         bia_pkg::S_IDLE: begin
            if (req_fire) begin
               case (req_ch.req_type)
                  bia_pkg::REQ_ALLOC: begin
                     row_in      = bia_pkg::row_of(hint_ff);
                     start_in    = bia_pkg::bit_of(hint_ff);
                     pass_in     = 1'b0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = bia_pkg::row_of(hint_ff);
                  end
                  bia_pkg::REQ_FREE: begin
                     row_in      = bia_pkg::row_of(free_idx);
                     start_in    = bia_pkg::bit_of(free_idx);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = bia_pkg::row_of(free_idx);
                  end
                  bia_pkg::REQ_INIT: begin
                     row_in  = '0;
                     hint_in = '0;
                     gen_in  = '0;
                     if (32'(reserved_ff) > 32'(bia_pkg::ENTRIES)) begin
                        rem_in = bia_pkg::CNT_W'(bia_pkg::ENTRIES);
                     end else begin
                        rem_in = bia_pkg::CNT_W'(reserved_ff);
                     end
                  end
                  default: begin
                     res_in  = '0;
                     stat_in = bia_pkg::STAT_DONE;
                  end
               endcase
            end
         end
         bia_pkg::S_SCAN: begin
            if (ffz_found) begin
               ram_wr_en       = 1'b1;
               ram_wr_data     = word_cur | (bia_pkg::WORD_BITS'(1) << ffz_pos);
               valid_in[row_ff] = 1'b1;
               res_in  = gen_ff | bia_pkg::ID_W'(bia_pkg::make_idx(row_ff, ffz_pos));
               stat_in = bia_pkg::STAT_ALLOC;
            end else if (last_row && pass_ff) begin
               res_in  = bia_pkg::ALL_ONES;
               stat_in = bia_pkg::STAT_FULL;
            end else begin
               // wrap after the first pass advances the generation
               if (last_row) begin
                  gen_in  = bia_pkg::next_gen(gen_ff, top_mask_ff);
                  pass_in = 1'b1;
               end
               row_in    = next_row;
               start_in  = '0;
               ram_rd_en = 1'b1;
            end
         end
         bia_pkg::S_FREE_WR: begin
            ram_wr_en        = 1'b1;
            ram_wr_data      = word_cur & ~(bia_pkg::WORD_BITS'(1) << start_ff);
            valid_in[row_ff] = 1'b1;
            if (bia_pkg::make_idx(row_ff, start_ff) < hint_ff) begin
               hint_in = bia_pkg::make_idx(row_ff, start_ff);
            end
            gen_in  = bia_pkg::next_gen(gen_ff, top_mask_ff);
            res_in  = '0;
            stat_in = bia_pkg::STAT_DONE;
         end
         bia_pkg::S_INIT: begin
            ram_wr_en        = 1'b1;
            valid_in[row_ff] = 1'b1;
            if (rem_ff >= bia_pkg::CNT_W'(bia_pkg::WORD_BITS)) begin
               ram_wr_data = '1;
               rem_in      = rem_ff - bia_pkg::CNT_W'(bia_pkg::WORD_BITS);
            end else begin
               ram_wr_data = ~({bia_pkg::WORD_BITS{1'b1}} << rem_ff[bia_pkg::BIT_W-1:0]);
               rem_in      = '0;
            end
            row_in  = next_row;
            res_in  = '0;
            stat_in = bia_pkg::STAT_DONE;
         end
         bia_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_ff;
               rsp_status_in = stat_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bia_pkg::S_IDLE;
         pass_ff      <= 1'b0;
         hint_ff      <= '0;
         gen_ff       <= '0;
         top_mask_ff  <= '0;
         reserved_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         hint_ff      <= hint_in;
         gen_ff       <= gen_in;
         top_mask_ff  <= top_mask_in;
         reserved_ff  <= reserved_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      start_ff      <= start_in;
      rem_ff        <= rem_in;
      res_ff        <= res_in;
      stat_ff       <= stat_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != bia_pkg::S_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_write_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == bia_pkg::S_SCAN || state_ff == bia_pkg::S_FREE_WR ||
                     state_ff == bia_pkg::S_INIT))
      else $error("bitmap written outside scan, free or init");

   a_full_is_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bia_pkg::STAT_FULL) |->
         rsp_id_ff == bia_pkg::ALL_ONES)
      else $error("pool full response without all-ones id");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bia_pkg::S_FINISH && rsp_free) |=> rsp_valid_ff)
      else $error("finished transaction not presented on response channel");

endmodule
